@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion sampled on the rising edge, inactive during reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Same, but also checked while reset is asserted
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hw/rtl/canrx_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// canrx_pkg
// Shared types and constants for the CAN receive acceptance/mailbox block.
// ---------------------------------------------------------------------------
package canrx_pkg;

    localparam logic [29:0] ID29_MASK = 30'h1fff_ffff;
    localparam logic [29:0] EXT_MARK  = 30'h2000_0000;
    localparam logic [29:0] ID11_MASK = 30'h0000_07ff;
    localparam logic [3:0]  LEN_MAX   = 4'd8;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_CONFIG = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // input item as decoded from s_tdata
    typedef struct packed {
        op_t         op;
        logic        channel;
        logic [3:0]  mailbox;
        logic        is_extended;
        logic [28:0] id_value;
        logic [28:0] id_mask;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic        use_ring;
        logic        raise_interrupt;
    } item_t;

    // classified command handed from the front end to the back end
    typedef struct packed {
        op_t         op;
        logic        channel;
        logic [3:0]  mailbox;
        logic [29:0] ident;      // normalized frame id or filter address
        logic [29:0] mask;       // normalized filter mask
        logic [3:0]  len;
        logic [63:0] payload;
        logic        use_ring;
        logic        raise_interrupt;
    } cmd_t;

    typedef struct packed {
        logic        matched;
        logic [3:0]  matched_mailbox;
        logic        read_valid;
        logic [3:0]  read_len;
        logic [29:0] read_id;
        logic [63:0] read_data;
        logic [15:0] pending_mask;
        logic [4:0]  ring_fill;
        logic [4:0]  ring_peak;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } exec_state_t;

endpackage

@@ hw/rtl/canrx_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// canrx_front
// Accepts items, normalizes identifiers and filters, caps the length, and
// pushes a command into a small queue toward the back end.
// ---------------------------------------------------------------------------
module canrx_front
    import canrx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  cmd_valid,
    input  logic  cmd_ready,
    output cmd_t  cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t           queue_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    cmd_t           cmd_in;
    logic           push, pop;

    always_comb begin
        cmd_in = '0;
        cmd_in.op = in_item.op;
        cmd_in.channel = in_item.channel;
        cmd_in.mailbox = in_item.mailbox;
        cmd_in.payload = in_item.payload;
        cmd_in.use_ring = in_item.use_ring;
        cmd_in.raise_interrupt = in_item.raise_interrupt;
        cmd_in.len = (in_item.dlc > LEN_MAX) ? LEN_MAX : in_item.dlc;
        if (in_item.op == OP_FRAME) begin
            cmd_in.ident = in_item.is_extended ? ({1'b0, in_item.id_value} | EXT_MARK)
                                               : ({1'b0, in_item.id_value} & ID11_MASK);
            cmd_in.mask = '0;
        end else if (in_item.is_extended) begin
            cmd_in.mask  = {1'b0, in_item.id_mask} | EXT_MARK;
            cmd_in.ident = {1'b0, in_item.id_value & in_item.id_mask} | EXT_MARK;
        end else begin
            cmd_in.mask  = {1'b0, in_item.id_mask} & ID11_MASK;
            cmd_in.ident = {1'b0, in_item.id_value & in_item.id_mask} & ID11_MASK;
        end
    end

    assign in_ready  = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ hw/rtl/canrx_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// canrx_back
// Executes commands: scan, mailbox/ring update, configure, reads, clears.
// Ring payloads live in a memory; filters and mailboxes are registers.
// ---------------------------------------------------------------------------
module canrx_back
    import canrx_pkg::*;
#(
    parameter int MAILBOX_COUNT = 16,
    parameter int RING_DEPTH    = 16,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int NE = CHANNEL_COUNT * MAILBOX_COUNT;
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int RE = CHANNEL_COUNT * RING_DEPTH;
    localparam int RAW = $clog2(RE);
    localparam int CHW = (CHANNEL_COUNT > 1) ? 1 : 1;

    // mailbox state
    logic [29:0] faddr_reg [NE];
    logic [29:0] fmask_reg [NE];
    logic [1:0]  mode_reg  [NE];
    logic [63:0] mdata_reg [NE];
    logic [29:0] mident_reg [NE];
    logic [3:0]  mlen_reg  [NE];
    logic [NE-1:0] mfull_reg;
    // ring state
    logic [97:0]  ring_mem [RE];
    logic [97:0]  ring_rd_reg;
    logic [RE-1:0] rfull_reg;
    logic [RW-1:0] wptr_reg [CHANNEL_COUNT];
    logic [RW-1:0] rptr_reg [CHANNEL_COUNT];
    logic [15:0]   pend_reg [CHANNEL_COUNT];
    logic [CW-1:0] cnt_reg  [CHANNEL_COUNT];
    logic [CW-1:0] peak_reg [CHANNEL_COUNT];

    exec_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    result_t     res_reg;
    result_t     res_next;
    result_t     res_out;
    logic        hit_ok_reg;
    logic [3:0]  hit_idx_reg;
    logic        hit_c;
    logic [3:0]  hit_idx_c;
    logic        scan_done_reg;
    logic        ch_ok;
    logic [CHW-1:0] ch;
    logic        mb_ok;
    logic [4:0]  base;
    logic [4:0]  k;
    logic [4:0]  hk;
    logic [RAW-1:0] wa, ra;
    logic [CW-1:0] cnt_inc;
    logic [RW-1:0] rptr_inc;

    assign ch    = cmd_reg.channel;
    assign ch_ok = (32'(cmd_reg.channel) < CHANNEL_COUNT);
    assign mb_ok = (32'(cmd_reg.mailbox) < MAILBOX_COUNT);
    assign base  = 5'(32'(cmd_reg.channel) * MAILBOX_COUNT);

    // priority scan of the channel's filters
    always_comb begin
        hit_c = 1'b0;
        hit_idx_c = '0;
        for (int i = MAILBOX_COUNT - 1; i >= 0; i--) begin
            if ((cmd_reg.ident & fmask_reg[5'(base + 5'(i))]) ==
                faddr_reg[5'(base + 5'(i))]) begin
                hit_c = 1'b1;
                hit_idx_c = 4'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd_valid) state_next = ST_EXEC;
            ST_EXEC: if (scan_done_reg) state_next = ST_OUT;
            ST_OUT:  if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_OUT);
    end
    assign res = res_out;

    assign k  = 5'(base + 5'(cmd_reg.mailbox));
    assign hk = 5'(base + 5'(hit_idx_reg));
    assign wa = RAW'(32'(ch) * RING_DEPTH + 32'(wptr_reg[ch]));
    assign ra = RAW'(32'(ch) * RING_DEPTH + 32'(rptr_reg[ch]));
    assign cnt_inc = (32'(cnt_reg[ch]) < RING_DEPTH) ? cnt_reg[ch] + 1'b1 : cnt_reg[ch];
    assign rptr_inc = (32'(rptr_reg[ch]) == RING_DEPTH - 1) ? '0 : rptr_reg[ch] + 1'b1;

    // ring memory: registered read while the command is loaded
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && cmd_valid) begin
            ring_rd_reg <= ring_mem[RAW'(32'(cmd.channel) * RING_DEPTH +
                                       32'(rptr_reg[CHW'(cmd.channel)]))];
        end
        if (state_reg == ST_EXEC && scan_done_reg && ch_ok && cmd_reg.op == OP_FRAME &&
            hit_ok_reg && mode_reg[hk][0]) begin
            ring_mem[wa] <= {cmd_reg.ident, cmd_reg.len, cmd_reg.payload};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && cmd_valid) begin
            cmd_reg <= cmd;
        end
    end

    // result fields of the command, from the registered scan and current state
    always_comb begin
        res_next = '0;
        if (ch_ok) begin
            case (cmd_reg.op)
                OP_FRAME: begin
                    if (hit_ok_reg) begin
                        res_next.matched = 1'b1;
                        res_next.matched_mailbox = hit_idx_reg;
                    end
                end
                OP_READ: begin
                    if (mb_ok) begin
                        if (mode_reg[k][0]) begin
                            if (rfull_reg[ra]) begin
                                res_next.read_valid = 1'b1;
                                res_next.read_id = ring_rd_reg[97:68];
                                res_next.read_len = ring_rd_reg[67:64];
                                res_next.read_data = ring_rd_reg[63:0];
                            end
                        end else if (mfull_reg[k]) begin
                            res_next.read_valid = 1'b1;
                            res_next.read_id = mident_reg[k];
                            res_next.read_len = mlen_reg[k];
                            res_next.read_data = mdata_reg[k];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // in ST_EXEC the scan is registered first, then the update is applied
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            scan_done_reg <= 1'b0;
            mfull_reg <= '0;
            rfull_reg <= '0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                wptr_reg[c] <= '0;
                rptr_reg[c] <= '0;
                pend_reg[c] <= '0;
                cnt_reg[c]  <= '0;
                peak_reg[c] <= '0;
            end
            for (int e = 0; e < NE; e++) begin
                faddr_reg[e] <= '0;
                fmask_reg[e] <= '0;
                mode_reg[e]  <= '0;
                mdata_reg[e] <= '0;
                mident_reg[e] <= '0;
                mlen_reg[e]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC && !scan_done_reg) begin
                scan_done_reg <= 1'b1;
                hit_ok_reg    <= hit_c;
                hit_idx_reg   <= hit_idx_c;
            end else if (state_reg == ST_EXEC) begin
                scan_done_reg <= 1'b0;
                res_reg <= res_next;
                if (ch_ok) begin
                    unique case (cmd_reg.op)
                        OP_FRAME: begin
                            if (hit_ok_reg) begin
                                if (mode_reg[hk][0]) begin
                                    rfull_reg[wa] <= 1'b1;
                                    wptr_reg[ch] <= (32'(wptr_reg[ch]) == RING_DEPTH - 1)
                                                    ? '0 : wptr_reg[ch] + 1'b1;
                                    cnt_reg[ch] <= cnt_inc;
                                    if (cnt_inc > peak_reg[ch]) peak_reg[ch] <= cnt_inc;
                                end else begin
                                    mdata_reg[hk] <= cmd_reg.payload;
                                    mident_reg[hk] <= cmd_reg.ident;
                                    mlen_reg[hk] <= cmd_reg.len;
                                    mfull_reg[hk] <= 1'b1;
                                end
                                if (mode_reg[hk][1]) pend_reg[ch][hit_idx_reg] <= 1'b1;
                            end
                        end
                        OP_CONFIG: begin
                            if (mb_ok) begin
                                fmask_reg[k] <= cmd_reg.mask;
                                faddr_reg[k] <= cmd_reg.ident;
                                mode_reg[k] <= {cmd_reg.raise_interrupt, cmd_reg.use_ring};
                                pend_reg[ch][cmd_reg.mailbox] <= 1'b0;
                                if (cmd_reg.use_ring) begin
                                    wptr_reg[ch] <= '0;
                                    rptr_reg[ch] <= '0;
                                    cnt_reg[ch] <= '0;
                                    for (int p = 0; p < RING_DEPTH; p++)
                                        rfull_reg[RAW'(32'(ch) * RING_DEPTH + p)] <= 1'b0;
                                end
                            end
                        end
                        OP_READ: begin
                            if (mb_ok) begin
                                if (mode_reg[k][0]) begin
                                    if (rfull_reg[ra]) begin
                                        rfull_reg[ra] <= 1'b0;
                                        rptr_reg[ch] <= rptr_inc;
                                        if (cnt_reg[ch] != '0) cnt_reg[ch] <= cnt_reg[ch] - 1'b1;
                                        if (mode_reg[k][1] && rptr_inc == wptr_reg[ch])
                                            pend_reg[ch][cmd_reg.mailbox] <= 1'b0;
                                        mfull_reg[k] <= 1'b0;
                                    end
                                end else if (mfull_reg[k]) begin
                                    if (mode_reg[k][1]) pend_reg[ch][cmd_reg.mailbox] <= 1'b0;
                                    mfull_reg[k] <= 1'b0;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            for (int m = 0; m < MAILBOX_COUNT; m++) begin
                                faddr_reg[5'(base + 5'(m))] <= '0;
                                fmask_reg[5'(base + 5'(m))] <= '0;
                                mode_reg[5'(base + 5'(m))]  <= '0;
                                mdata_reg[5'(base + 5'(m))] <= '0;
                                mident_reg[5'(base + 5'(m))] <= '0;
                                mlen_reg[5'(base + 5'(m))]  <= '0;
                                mfull_reg[5'(base + 5'(m))] <= 1'b0;
                            end
                            for (int p = 0; p < RING_DEPTH; p++)
                                rfull_reg[RAW'(32'(ch) * RING_DEPTH + p)] <= 1'b0;
                            pend_reg[ch] <= '0;
                            wptr_reg[ch] <= '0;
                            rptr_reg[ch] <= '0;
                            cnt_reg[ch]  <= '0;
                            peak_reg[ch] <= '0;
                        end
                        default: ;
                    endcase
                end
            end
            if (state_reg == ST_IDLE) scan_done_reg <= 1'b0;
        end
    end

    // status fields reflect the channel after the update; stable while in ST_OUT
    always_comb begin
        res_out = res_reg;
        if (ch_ok) begin
            res_out.pending_mask = pend_reg[ch];
            res_out.ring_fill = 5'(cnt_reg[ch]);
            res_out.ring_peak = 5'(peak_reg[ch]);
        end
    end

endmodule

@@ hw/rtl/can_rx_acceptance_mailboxes_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// can_rx_acceptance_mailboxes_top
// Two-channel CAN receive acceptance filter with mailboxes and receive rings.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transfer: frame receive, configure,
//   read or clear. m_axis returns exactly one result per command, in order.
//   A two-entry command queue decouples the input side from execution, so
//   two commands are taken while a result waits on m_axis.
//   Each command passes through the execute unit in order (command load,
//   16-entry priority filter scan, state update, result); the next command
//   is loaded only after the result is taken, so commands do not overlap.
//   When idle, an input transfer passes through the command queue and then
//   these steps before its result is valid.
//   After reset all filters have zero mask (accept any frame), all
//   mailboxes and rings are empty and the queue is empty.
//   When m_tready is low the result holds, execution stops and the queue
//   fills; s_tready then drops.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module can_rx_acceptance_mailboxes_top
    import canrx_pkg::*;
#(
    parameter int MAILBOX_COUNT = 16,
    parameter int RING_DEPTH    = 16,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, channel, mailbox, is_extended, id_value, id_mask, dlc, payload,
    // use_ring, raise_interrupt (from bit 0 up)
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // matched, matched_mailbox, read_valid, read_len, read_id, read_data,
    // pending_mask, ring_fill, ring_peak (from bit 0 up), 6 zero bits
    output logic [135:0] m_tdata
);

    item_t   item;
    cmd_t    cmd;
    logic    cmd_valid, cmd_ready;
    result_t res;

    assign item.op              = op_t'(s_tdata[1:0]);
    assign item.channel         = s_tdata[2];
    assign item.mailbox         = s_tdata[6:3];
    assign item.is_extended     = s_tdata[7];
    assign item.id_value        = s_tdata[36:8];
    assign item.id_mask         = s_tdata[65:37];
    assign item.dlc             = s_tdata[69:66];
    assign item.payload         = s_tdata[133:70];
    assign item.use_ring        = s_tdata[134];
    assign item.raise_interrupt = s_tdata[135];

    canrx_front #(.QUEUE_DEPTH(2)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(item),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    canrx_back #(
        .MAILBOX_COUNT(MAILBOX_COUNT), .RING_DEPTH(RING_DEPTH),
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {6'b0, res.ring_peak, res.ring_fill, res.pending_mask,
                      res.read_data, res.read_id, res.read_len, res.read_valid,
                      res.matched_mailbox, res.matched};

    `ASSERT_CLK(a_match_excl, aclk, aresetn,
        m_tvalid |-> !(res.matched && res.read_valid), "match and read both set")
    `ASSERT_CLK(a_res_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")
    `ASSERT_CLK(a_len_cap, aclk, aresetn,
        m_tvalid |-> (res.read_len <= LEN_MAX), "read length above eight")
    `ASSERT_ALWAYS(a_reset_quiet, aclk,
        !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

@@ bench/can_rx_acceptance_mailboxes_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// can_rx_acceptance_mailboxes_top_tb
// Drives frames, filter setups, mailbox reads and channel clears into the CAN
// receive filter, predicts results with a behavioral mailbox/ring model (or
// hand-written for some rows) and checks every m_axis transfer field by field.
// ---------------------------------------------------------------------------
module can_rx_acceptance_mailboxes_top_tb;
    import canrx_pkg::*;

    localparam int MBOXES     = 16;
    localparam int RING_SLOTS = 16;
    localparam int WDOG_LIMIT = 5000;
    localparam int PRESSURE_AT = 300;

    typedef struct {
        op_t         op;
        logic        channel;
        logic [3:0]  mailbox;
        logic        is_ext;
        logic [28:0] id_value;
        logic [28:0] id_mask;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic        use_ring;
        logic        irq;
    } rx_cmd_t;

    typedef struct {
        logic        matched;
        logic [3:0]  hit_mbox;
        logic        rd_valid;
        logic [3:0]  rd_len;
        logic [29:0] rd_id;
        logic [63:0] rd_data;
        logic [15:0] pending;
        logic [4:0]  fill;
        logic [4:0]  peak;
    } rx_res_t;

    typedef struct {
        rx_cmd_t cmd;
        bit      has_res;
        rx_res_t res;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;

    can_rx_acceptance_mailboxes_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow state of the filter block
    logic [29:0] flt_addr [2][MBOXES];
    logic [29:0] flt_mask [2][MBOXES];
    logic        mb_ring  [2][MBOXES];
    logic        mb_irq   [2][MBOXES];
    logic [63:0] mb_data  [2][MBOXES];
    logic [29:0] mb_id    [2][MBOXES];
    logic [3:0]  mb_len   [2][MBOXES];
    logic        mb_full  [2][MBOXES];
    logic [63:0] rg_data  [2][RING_SLOTS];
    logic [29:0] rg_id    [2][RING_SLOTS];
    logic [3:0]  rg_len   [2][RING_SLOTS];
    logic        rg_full  [2][RING_SLOTS];
    logic [3:0]  rg_wr    [2];
    logic [3:0]  rg_rd    [2];
    logic [15:0] pend_bits[2];
    logic [4:0]  rg_count [2];
    logic [4:0]  rg_peak  [2];

    rx_res_t  expected_results[$];
    dir_row_t dir_rows[$];
    int       errors = 0;
    int       results_seen = 0;
    int       idle_cycles = 0;
    bit       stim_done = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        aresetn  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic void clear_ring(int ch);
        rg_wr[ch] = '0;
        rg_rd[ch] = '0;
        rg_count[ch] = '0;
        for (int p = 0; p < RING_SLOTS; p++) rg_full[ch][p] = 1'b0;
    endfunction

    function automatic void clear_channel(int ch);
        for (int m = 0; m < MBOXES; m++) begin
            flt_addr[ch][m] = '0;
            flt_mask[ch][m] = '0;
            mb_ring[ch][m]  = 1'b0;
            mb_irq[ch][m]   = 1'b0;
            mb_data[ch][m]  = '0;
            mb_id[ch][m]    = '0;
            mb_len[ch][m]   = '0;
            mb_full[ch][m]  = 1'b0;
        end
        pend_bits[ch] = '0;
        clear_ring(ch);
        rg_peak[ch] = '0;
    endfunction

    function automatic rx_res_t predict_mailbox_step(rx_cmd_t c);
        rx_res_t     r;
        int          ch;
        int          hit;
        logic [29:0] rid;
        r = '{default: '0};
        ch = c.channel;
        case (c.op)
            OP_FRAME: begin
                rid = c.is_ext ? ({1'b0, c.id_value} | EXT_MARK)
                               : ({1'b0, c.id_value} & ID11_MASK);
                hit = -1;
                for (int m = 0; m < MBOXES; m++)
                    if (hit < 0 && (rid & flt_mask[ch][m]) == flt_addr[ch][m]) hit = m;
                if (hit >= 0) begin
                    if (mb_ring[ch][hit]) begin
                        rg_data[ch][rg_wr[ch]] = c.payload;
                        rg_id[ch][rg_wr[ch]]   = rid;
                        rg_len[ch][rg_wr[ch]]  = (c.dlc > 8) ? 4'd8 : c.dlc;
                        rg_full[ch][rg_wr[ch]] = 1'b1;
                        rg_wr[ch] = rg_wr[ch] + 1'b1;
                        if (rg_count[ch] < RING_SLOTS) rg_count[ch]++;
                        if (rg_count[ch] > rg_peak[ch]) rg_peak[ch] = rg_count[ch];
                    end else begin
                        mb_data[ch][hit] = c.payload;
                        mb_id[ch][hit]   = rid;
                        mb_len[ch][hit]  = (c.dlc > 8) ? 4'd8 : c.dlc;
                        mb_full[ch][hit] = 1'b1;
                    end
                    if (mb_irq[ch][hit]) pend_bits[ch][hit] = 1'b1;
                    r.matched  = 1'b1;
                    r.hit_mbox = hit[3:0];
                end
            end
            OP_CONFIG: begin
                if (c.is_ext) begin
                    flt_mask[ch][c.mailbox] = {1'b0, c.id_mask} | EXT_MARK;
                    flt_addr[ch][c.mailbox] = {1'b0, c.id_value & c.id_mask} | EXT_MARK;
                end else begin
                    flt_mask[ch][c.mailbox] = {1'b0, c.id_mask} & ID11_MASK;
                    flt_addr[ch][c.mailbox] = {1'b0, c.id_value & c.id_mask} & ID11_MASK;
                end
                mb_ring[ch][c.mailbox] = c.use_ring;
                mb_irq[ch][c.mailbox]  = c.irq;
                pend_bits[ch][c.mailbox] = 1'b0;
                if (c.use_ring) clear_ring(ch);
            end
            OP_READ: begin
                if (mb_ring[ch][c.mailbox]) begin
                    if (rg_full[ch][rg_rd[ch]]) begin
                        r.rd_valid = 1'b1;
                        r.rd_len   = rg_len[ch][rg_rd[ch]];
                        r.rd_id    = rg_id[ch][rg_rd[ch]];
                        r.rd_data  = rg_data[ch][rg_rd[ch]];
                        rg_full[ch][rg_rd[ch]] = 1'b0;
                        rg_rd[ch] = rg_rd[ch] + 1'b1;
                        if (rg_count[ch] > 0) rg_count[ch]--;
                        if (mb_irq[ch][c.mailbox] && rg_rd[ch] == rg_wr[ch])
                            pend_bits[ch][c.mailbox] = 1'b0;
                        mb_full[ch][c.mailbox] = 1'b0;
                    end
                end else if (mb_full[ch][c.mailbox]) begin
                    r.rd_valid = 1'b1;
                    r.rd_len   = mb_len[ch][c.mailbox];
                    r.rd_id    = mb_id[ch][c.mailbox];
                    r.rd_data  = mb_data[ch][c.mailbox];
                    if (mb_irq[ch][c.mailbox]) pend_bits[ch][c.mailbox] = 1'b0;
                    mb_full[ch][c.mailbox] = 1'b0;
                end
            end
            default: clear_channel(ch);
        endcase
        r.pending = pend_bits[ch];
        r.fill    = rg_count[ch];
        r.peak    = rg_peak[ch];
        return r;
    endfunction

    function automatic rx_cmd_t mk_cmd(op_t op, bit ch, logic [3:0] mb, bit ext,
                                       logic [28:0] idv, logic [28:0] idm,
                                       logic [3:0] dlc, logic [63:0] pl,
                                       bit ring, bit irq);
        rx_cmd_t c;
        c.op = op; c.channel = ch; c.mailbox = mb; c.is_ext = ext;
        c.id_value = idv; c.id_mask = idm; c.dlc = dlc; c.payload = pl;
        c.use_ring = ring; c.irq = irq;
        return c;
    endfunction

    function automatic void add_row(rx_cmd_t c, bit has_res, rx_res_t r);
        dir_row_t d;
        d.cmd = c; d.has_res = has_res; d.res = r;
        dir_rows.push_back(d);
    endfunction

    function automatic rx_cmd_t random_cmd();
        rx_cmd_t     c;
        int          sel;
        int          m;
        logic [29:0] a;
        logic [29:0] k;
        logic [29:0] id;
        c = mk_cmd(OP_FRAME, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 29'($urandom), 29'($urandom),
                   4'($urandom_range(0, 15)), {$urandom, $urandom},
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sel = $urandom_range(0, 99);
        if (sel < 48) begin
            c.op = OP_FRAME;
            // mostly aim the id at some mailbox's filter
            if ($urandom_range(0, 9) < 7) begin
                m = $urandom_range(0, 15);
                a = flt_addr[c.channel][m];
                k = flt_mask[c.channel][m];
                id = a | (30'($urandom) & ~k);
                c.id_value = id[28:0];
                c.is_ext = a[29] ? 1'b1 : (k[29] ? 1'b0 : 1'($urandom_range(0, 1)));
            end
        end else if (sel < 63) begin
            c.op = OP_CONFIG;
            case ($urandom_range(0, 3))
                0: c.id_mask = '0;
                1: c.id_mask = '1;
                2: c.id_mask = 29'($urandom) & 29'h0000_07ff;
                default: ;
            endcase
            c.use_ring = ($urandom_range(0, 9) < 3);
        end else if (sel < 97) begin
            c.op = OP_READ;
        end else begin
            c.op = OP_CLEAR;
        end
        return c;
    endfunction

    task automatic send_cmd(rx_cmd_t c, bit has_res, rx_res_t typed);
        rx_res_t r;
        s_tdata  <= {c.irq, c.use_ring, c.payload, c.dlc, c.id_mask, c.id_value,
                     c.is_ext, c.mailbox, c.channel, c.op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = predict_mailbox_step(c);
        expected_results.push_back(has_res ? typed : r);
    endtask

    task automatic source_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 60) return;
        g = (g < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        s_tvalid <= 1'b0;
        repeat (g) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        rx_res_t z;
        rx_res_t e;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        z = '{default: '0};
        for (int ch = 0; ch < 2; ch++) clear_channel(ch);
        for (int ch = 0; ch < 2; ch++)
            for (int p = 0; p < RING_SLOTS; p++) begin
                rg_data[ch][p] = '0; rg_id[ch][p] = '0; rg_len[ch][p] = '0;
            end

        // cleared filters accept anything: mailbox 0 takes it
        e = z; e.matched = 1'b1;
        add_row(mk_cmd(OP_FRAME, 0, 0, 1, '1, '0, 4'hf, '1, 0, 0), 1, e);
        e = z; e.rd_valid = 1'b1; e.rd_len = 4'd8; e.rd_id = 30'h3fff_ffff; e.rd_data = '1;
        add_row(mk_cmd(OP_READ, 0, 0, 0, '0, '0, 0, '0, 0, 0), 1, e);
        add_row(mk_cmd(OP_READ, 0, 0, 0, '0, '0, 0, '0, 0, 0), 1, z);
        add_row(mk_cmd(OP_READ, 0, 15, 0, '0, '0, 0, '0, 0, 0), 1, z);
        e = z; e.matched = 1'b1;
        add_row(mk_cmd(OP_FRAME, 1, 0, 0, '0, '0, 4'd0, '0, 0, 0), 1, e);
        add_row(mk_cmd(OP_CONFIG, 1, 0, 0, 29'h123, 29'h7ff, 0, '0, 1, 1), 0, z);
        add_row(mk_cmd(OP_FRAME, 1, 0, 0, 29'h1fff_f123, '0, 4'd3, 64'h0123_4567_89ab_cdef,
                       0, 0), 0, z);
        add_row(mk_cmd(OP_FRAME, 1, 0, 0, 29'h124, '0, 4'd9, '1, 0, 0), 0, z);
        add_row(mk_cmd(OP_READ, 1, 0, 0, '0, '0, 0, '0, 0, 0), 0, z);
        add_row(mk_cmd(OP_CONFIG, 1, 1, 1, '0, '1, 0, '0, 0, 1), 0, z);
        add_row(mk_cmd(OP_FRAME, 1, 0, 1, '0, '0, 4'd8, '0, 0, 0), 0, z);
        add_row(mk_cmd(OP_READ, 1, 1, 0, '0, '0, 0, '0, 0, 0), 0, z);
        // ring overflow: 17 frames into a 16-entry ring
        for (int i = 0; i < 17; i++)
            add_row(mk_cmd(OP_FRAME, 1, 0, 0, 29'h123, '0, i[3:0], {2{i}}, 0, 0), 0, z);
        add_row(mk_cmd(OP_READ, 1, 0, 0, '0, '0, 0, '0, 0, 0), 0, z);
        add_row(mk_cmd(OP_CLEAR, 1, 0, 0, '0, '0, 0, '0, 0, 0), 1, z);

        @(posedge aclk iff aresetn);
        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].cmd, dir_rows[i].has_res, dir_rows[i].res);
            source_gap();
        end
        for (int i = 0; i < 1000; i++) begin
            send_cmd(random_cmd(), 0, z);
            source_gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // result side: compare, then pick next m_tready
    initial begin
        rx_res_t w;
        int      hold;
        int      squeeze;
        m_tready = 1'b0;
        hold = 0;
        squeeze = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report("unexpected transfer", m_tdata[63:0], '0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_tdata[0] !== w.matched)
                        report("matched", 64'(m_tdata[0]), 64'(w.matched));
                    if (m_tdata[4:1] !== w.hit_mbox)
                        report("matched_mailbox", 64'(m_tdata[4:1]), 64'(w.hit_mbox));
                    if (m_tdata[5] !== w.rd_valid)
                        report("read_valid", 64'(m_tdata[5]), 64'(w.rd_valid));
                    if (m_tdata[9:6] !== w.rd_len)
                        report("read_len", 64'(m_tdata[9:6]), 64'(w.rd_len));
                    if (m_tdata[39:10] !== w.rd_id)
                        report("read_id", 64'(m_tdata[39:10]), 64'(w.rd_id));
                    if (m_tdata[103:40] !== w.rd_data)
                        report("read_data", m_tdata[103:40], w.rd_data);
                    if (m_tdata[119:104] !== w.pending)
                        report("pending_mask", 64'(m_tdata[119:104]), 64'(w.pending));
                    if (m_tdata[124:120] !== w.fill)
                        report("ring_fill", 64'(m_tdata[124:120]), 64'(w.fill));
                    if (m_tdata[129:125] !== w.peak)
                        report("ring_peak", 64'(m_tdata[129:125]), 64'(w.peak));
                end
                if (results_seen == PRESSURE_AT) squeeze = 300;
            end
            if (squeeze > 0) begin
                squeeze--;
                m_tready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 80) begin
                m_tready <= 1'b1;
            end else begin
                hold = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            @(posedge aclk);
        end
    end

    // watchdog on transfer activity
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_results.size() == 0);
        repeat (30) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
